### src/pt_pkg.sv
// Shared types and constants for the point-to-triangle squared-distance unit.
// Request and response payload structs, region codes, fixed field widths.
// No dependencies.
package pt_pkg;

    localparam int COORD_BITS         = 24;
    localparam int DIST_BITS          = 52;
    localparam int QUOT_FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_AB   = 3'd2,
        REG_C    = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } t_region;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        t_coord vert_a_x;
        t_coord vert_a_y;
        t_coord vert_a_z;
        t_coord vert_b_x;
        t_coord vert_b_y;
        t_coord vert_b_z;
        t_coord vert_c_x;
        t_coord vert_c_y;
        t_coord vert_c_z;
    } t_pt_req;

    typedef struct packed {
        logic [DIST_BITS-1:0] dist_squared;
        logic [2:0]           closest_region;
        logic                 degenerate;
    } t_pt_rsp;

endpackage

### src/pt_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// Stage one forms the partials, stage two aligns and sums them.
// No dependencies.
module pt_mul #(
    parameter int AW = 53
) (
    input  logic                   i_clk,
    input  logic signed [AW-1:0]   i_a,
    input  logic signed [AW-1:0]   i_b,
    output logic signed [2*AW-1:0] o_p
);

    localparam int L = AW / 2;
    localparam int H = AW - L;

    logic signed [H-1:0]     ah, bh;
    logic signed [L:0]       al, bl;
    logic signed [2*H-1:0]   r_hh;
    logic signed [H+L:0]     r_hl, r_lh;
    logic signed [2*L+1:0]   r_ll;
    logic signed [2*AW-1:0]  r_p;

    assign ah = i_a[AW-1:L];
    assign bh = i_b[AW-1:L];
    assign al = {1'b0, i_a[L-1:0]};
    assign bl = {1'b0, i_b[L-1:0]};

    always_ff @(posedge i_clk) begin
        r_hh <= ah * bh;
        r_hl <= ah * bl;
        r_lh <= al * bh;
        r_ll <= al * bl;
        r_p  <= ((2*AW)'(r_hh) <<< (2*L))
              + (((2*AW)'(r_hl) + (2*AW)'(r_lh)) <<< L)
              + (2*AW)'(r_ll);
    end

    assign o_p = r_p;

endmodule

### src/pt_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
// Carries a valid bit and an opaque payload alongside each division.
// No dependencies.
module pt_div #(
    parameter int MW = 120,
    parameter int QM = 17,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [MW-1:0] i_num,
    input  logic [MW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [QM-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic          r_vld [QM];
    logic [MW-1:0] r_rem [QM];
    logic [MW-1:0] r_den [QM];
    logic [QM-1:0] r_quo [QM];
    logic [PW-1:0] r_pay [QM];

    for (genvar k = 0; k < QM; k++) begin : g_stg
        localparam int B = QM - 1 - k;
        logic             p_vld;
        logic [MW-1:0]    p_rem, p_den, n_rem;
        logic [QM-1:0]    p_quo, n_quo;
        logic [PW-1:0]    p_pay;
        logic [MW+QM-1:0] trial;

        if (k == 0) begin : g_in
            assign p_vld = i_vld;
            assign p_rem = i_num;
            assign p_den = i_den;
            assign p_quo = '0;
            assign p_pay = i_pay;
        end else begin : g_mid
            assign p_vld = r_vld[k-1];
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_quo = r_quo[k-1];
            assign p_pay = r_pay[k-1];
        end

        assign trial = (MW+QM)'(p_den) << B;

        // subtract the shifted divisor when it fits, set this quotient bit
        always_comb begin
            if ((MW+QM)'(p_rem) >= trial) begin
                n_rem = p_rem - trial[MW-1:0];
                n_quo = p_quo | (QM'(1) << B);
            end else begin
                n_rem = p_rem;
                n_quo = p_quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_den[k] <= p_den;
            r_quo[k] <= n_quo;
            r_pay[k] <= p_pay;
        end
    end

    assign o_vld = r_vld[QM-1];
    assign o_quo = r_quo[QM-1];
    assign o_pay = r_pay[QM-1];

endmodule

### src/point_triangle_distance_squared_unit.sv
// Point-to-triangle squared distance, closest-feature region and degenerate flag.
// Uses pt_pkg, pt_mul (split multiplier) and pt_div (pipelined divider).
//
// A new request is taken in every clock cycle in which start is high; busy
// never rises, so requests may stream back to back without gaps. Each
// request yields exactly one response, shown for one cycle with o_valid
// high. The receiver cannot hold responses off, and none is needed: the
// pipeline never stalls. The divider resolves one quotient bit per stage;
// everything else is a fixed chain of edge vectors, dot products, split
// wide multiplies for the region determinants, the region tests, and the
// final squared length.
module point_triangle_distance_squared_unit
    import pt_pkg::*;
#(
    parameter int QUOT_FRAC_BITS = QUOT_FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_pt_req i_req,
    output logic    o_valid,
    output t_pt_rsp o_rsp
);

    localparam int Q    = QUOT_FRAC_BITS;
    localparam int D    = COORD_BITS + 1;  // coordinate difference
    localparam int PD   = 2 * D;           // one dot-product term
    localparam int DW   = 2 * D + 2;       // dot product
    localparam int VW   = 2 * DW + 1;      // region determinant
    localparam int SW   = VW + Q + 3;      // signed numerator and divisor
    localparam int QM   = Q + 1;           // quotient magnitude, weight in [0,1]
    localparam int TW   = QM + 1;          // signed weight
    localparam int EW   = D + TW;          // edge times weight
    localparam int XW   = D + Q + 4;       // offset component
    localparam int SQ   = 2 * XW;
    localparam int SS   = SQ + 2;

    typedef logic [2:0][D-1:0] t_vec;

    typedef struct packed {
        t_vec ab;
        t_vec ac;
        t_vec cb;
        t_vec ap;
        t_vec bp;
        t_vec cp;
    } t_ctx;

    typedef struct packed {
        logic [2:0] region;
        logic       dgn;
        logic       sn;
        t_vec       base;
        t_vec       e1;
        t_vec       e2;
    } t_pay;

    localparam int PAYW = $bits(t_pay);

    // ---------------------------------------------------------------
    // Stage 1: edge and offset vectors
    // ---------------------------------------------------------------
    t_coord q_p [3];
    t_coord q_a [3];
    t_coord q_b [3];
    t_coord q_c [3];
    t_ctx   n1_ctx;
    t_ctx   r1_ctx;
    logic   r1_vld;

    assign busy = 1'b0;

    always_comb begin
        q_p[0] = i_req.point_x;  q_p[1] = i_req.point_y;  q_p[2] = i_req.point_z;
        q_a[0] = i_req.vert_a_x; q_a[1] = i_req.vert_a_y; q_a[2] = i_req.vert_a_z;
        q_b[0] = i_req.vert_b_x; q_b[1] = i_req.vert_b_y; q_b[2] = i_req.vert_b_z;
        q_c[0] = i_req.vert_c_x; q_c[1] = i_req.vert_c_y; q_c[2] = i_req.vert_c_z;
        for (int j = 0; j < 3; j++) begin
            n1_ctx.ab[j] = D'(q_b[j]) - D'(q_a[j]);
            n1_ctx.ac[j] = D'(q_c[j]) - D'(q_a[j]);
            n1_ctx.cb[j] = D'(q_c[j]) - D'(q_b[j]);
            n1_ctx.ap[j] = D'(q_p[j]) - D'(q_a[j]);
            n1_ctx.bp[j] = D'(q_p[j]) - D'(q_b[j]);
            n1_ctx.cp[j] = D'(q_p[j]) - D'(q_c[j]);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: the eighteen dot-product terms
    // d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
    // ---------------------------------------------------------------
    logic signed [PD-1:0] n2_pr [6][3];
    logic signed [PD-1:0] r2_pr [6][3];
    t_ctx                 r2_ctx;
    logic                 r2_vld;

    always_comb begin
        t_vec fv;
        t_vec sv;
        for (int k = 0; k < 6; k++) begin
            fv = (k % 2 == 0) ? r1_ctx.ab : r1_ctx.ac;
            sv = (k / 2 == 0) ? r1_ctx.ap : ((k / 2 == 1) ? r1_ctx.bp : r1_ctx.cp);
            for (int j = 0; j < 3; j++) begin
                n2_pr[k][j] = $signed(fv[j]) * $signed(sv[j]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: dot products; stages 4-5 carry them past the multipliers
    // ---------------------------------------------------------------
    logic signed [DW-1:0] r3_d [6];
    logic signed [DW-1:0] r4_d [6];
    logic signed [DW-1:0] r5_d [6];
    logic signed [DW-1:0] r6_d [6];
    t_ctx                 r3_ctx, r4_ctx, r5_ctx, r6_ctx;
    logic                 r3_vld, r4_vld, r5_vld, r6_vld;

    // determinant products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    logic signed [2*DW-1:0] vm [6];

    for (genvar g = 0; g < 6; g++) begin : g_vm
        localparam int IA = (2 * g) % 6;
        localparam int IB = (g == 0 || g == 5) ? 3 : ((g == 1 || g == 2) ? 1 : 5);
        pt_mul #(.AW(DW)) u_mul (
            .i_clk (i_clk),
            .i_a   (r3_d[IA]),
            .i_b   (r3_d[IB]),
            .o_p   (vm[g])
        );
    end

    // Stage 6: determinants vc, vb, va
    logic signed [VW-1:0] r6_vc, r6_vb, r6_va;

    // ---------------------------------------------------------------
    // Stage 7: region tests, divider operands, offset terms
    // ---------------------------------------------------------------
    logic signed [DW:0]   s7_e43, s7_e56;
    logic signed [SW-1:0] s7_n0, s7_n1, s7_den;
    t_region              s7_region;
    t_pay                 n7_pay;
    logic [SW-1:0]        r7_n0, r7_n1, r7_den;
    t_pay                 r7_pay;
    logic                 r7_sn1;
    logic                 r7_vld;

    function automatic logic [SW-1:0] f_mag(input logic signed [SW-1:0] x);
        return x[SW-1] ? SW'(-x) : SW'(x);
    endfunction

    always_comb begin
        s7_e43    = (DW+1)'(r6_d[3]) - (DW+1)'(r6_d[2]);
        s7_e56    = (DW+1)'(r6_d[4]) - (DW+1)'(r6_d[5]);
        s7_n0     = '0;
        s7_n1     = '0;
        s7_den    = SW'(1);
        s7_region = REG_FACE;
        n7_pay    = '0;
        n7_pay.base = r6_ctx.ap;

        // order matters: first matching test wins
        priority if (r6_d[0] <= 0 && r6_d[1] <= 0) begin
            s7_region   = REG_A;
        end else if (r6_d[2] >= 0 && s7_e43 <= 0) begin
            s7_region   = REG_B;
            n7_pay.base = r6_ctx.bp;
        end else if (r6_vc <= 0 && r6_d[0] >= 0 && r6_d[2] <= 0) begin
            s7_region   = REG_AB;
            s7_n0       = SW'(r6_d[0]) <<< Q;
            s7_den      = SW'(r6_d[0]) - SW'(r6_d[2]);
            n7_pay.e1   = r6_ctx.ab;
        end else if (r6_d[5] >= 0 && s7_e56 <= 0) begin
            s7_region   = REG_C;
            n7_pay.base = r6_ctx.cp;
        end else if (r6_vb <= 0 && r6_d[1] >= 0 && r6_d[5] <= 0) begin
            s7_region   = REG_AC;
            s7_n0       = SW'(r6_d[1]) <<< Q;
            s7_den      = SW'(r6_d[1]) - SW'(r6_d[5]);
            n7_pay.e1   = r6_ctx.ac;
        end else if (r6_va <= 0 && s7_e43 >= 0 && s7_e56 >= 0) begin
            s7_region   = REG_BC;
            s7_n0       = SW'(s7_e43) <<< Q;
            s7_den      = SW'(s7_e43) + SW'(s7_e56);
            n7_pay.base = r6_ctx.bp;
            n7_pay.e1   = r6_ctx.cb;
        end else begin
            s7_region   = REG_FACE;
            s7_n0       = SW'(r6_vb) <<< Q;
            s7_n1       = SW'(r6_vc) <<< Q;
            s7_den      = SW'(r6_va) + SW'(r6_vb) + SW'(r6_vc);
            n7_pay.e1   = r6_ctx.ab;
            n7_pay.e2   = r6_ctx.ac;
        end

        n7_pay.region = s7_region;
        n7_pay.sn     = s7_n0[SW-1] ^ s7_den[SW-1];
        // zero divisor: fall back to the distance to vertex a
        n7_pay.dgn    = (s7_den == '0);
        if (n7_pay.dgn) begin
            n7_pay.base = r6_ctx.ap;
        end
    end

    // ---------------------------------------------------------------
    // Divider lanes: lane 0 carries the payload, lane 1 the face weight w
    // ---------------------------------------------------------------
    logic            d0_vld, d1_vld;
    logic [QM-1:0]   d0_quo, d1_quo;
    logic [PAYW-1:0] d0_pay;
    logic            d1_sn;

    pt_div #(.MW(SW), .QM(QM), .PW(PAYW)) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r7_vld),
        .i_num   (r7_n0),
        .i_den   (r7_den),
        .i_pay   (r7_pay),
        .o_vld   (d0_vld),
        .o_quo   (d0_quo),
        .o_pay   (d0_pay)
    );

    pt_div #(.MW(SW), .QM(QM), .PW(1)) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r7_vld),
        .i_num   (r7_n1),
        .i_den   (r7_den),
        .i_pay   (r7_sn1),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_pay   (d1_sn)
    );

    // ---------------------------------------------------------------
    // Stage A: signed weights, edge times weight
    // ---------------------------------------------------------------
    t_pay                 sa_pay;
    logic signed [TW-1:0] sa_t, sa_u;
    logic signed [EW-1:0] ra_p1 [3];
    logic signed [EW-1:0] ra_p2 [3];
    t_vec                 ra_base;
    logic [2:0]           ra_region;
    logic                 ra_dgn;
    logic                 ra_vld;

    always_comb begin
        sa_pay = t_pay'(d0_pay);
        sa_t   = sa_pay.sn ? -$signed({1'b0, d0_quo}) : $signed({1'b0, d0_quo});
        sa_u   = d1_sn ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
        if (sa_pay.dgn) begin
            sa_t = '0;
            sa_u = '0;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: offset from the closest point, Q extra fraction bits
    // ---------------------------------------------------------------
    logic signed [XW-1:0] rb_x [3];
    logic [2:0]           rb_region;
    logic                 rb_dgn;
    logic                 rb_vld;

    logic signed [SQ-1:0] sq [3];

    for (genvar g = 0; g < 3; g++) begin : g_sq
        pt_mul #(.AW(XW)) u_mul (
            .i_clk (i_clk),
            .i_a   (rb_x[g]),
            .i_b   (rb_x[g]),
            .o_p   (sq[g])
        );
    end

    logic [2:0] rc_region, rd_region;
    logic       rc_dgn, rd_dgn;
    logic       rc_vld, rd_vld;

    // ---------------------------------------------------------------
    // Stage E: sum of squares, drop the extra fraction bits, saturate
    // ---------------------------------------------------------------
    logic signed [SS-1:0] se_sum;
    logic [SS-1:0]        se_sh;
    logic [DIST_BITS-1:0] se_dist;
    t_pt_rsp              r_rsp;
    logic                 r_out_vld;

    always_comb begin
        se_sum = SS'(sq[0]) + SS'(sq[1]) + SS'(sq[2]);
        se_sh  = $unsigned(se_sum) >> (2 * Q);
        if (|se_sh[SS-1:DIST_BITS]) begin
            se_dist = '1;
        end else begin
            se_dist = se_sh[DIST_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Valid bits: clear on reset, advance every cycle
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            ra_vld    <= 1'b0;
            rb_vld    <= 1'b0;
            rc_vld    <= 1'b0;
            rd_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r1_vld    <= start & ~busy;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            ra_vld    <= d0_vld & d1_vld;
            rb_vld    <= ra_vld;
            rc_vld    <= rb_vld;
            rd_vld    <= rc_vld;
            r_out_vld <= rd_vld;
        end
    end

    // ---------------------------------------------------------------
    // Data path registers: no reset, follow the valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r1_ctx <= n1_ctx;

        r2_ctx <= r1_ctx;
        r2_pr  <= n2_pr;

        r3_ctx <= r2_ctx;
        for (int k = 0; k < 6; k++) begin
            r3_d[k] <= DW'(r2_pr[k][0]) + DW'(r2_pr[k][1]) + DW'(r2_pr[k][2]);
        end

        r4_ctx <= r3_ctx;
        r4_d   <= r3_d;
        r5_ctx <= r4_ctx;
        r5_d   <= r4_d;

        r6_ctx <= r5_ctx;
        r6_d   <= r5_d;
        r6_vc  <= VW'(vm[0]) - VW'(vm[1]);
        r6_vb  <= VW'(vm[2]) - VW'(vm[3]);
        r6_va  <= VW'(vm[4]) - VW'(vm[5]);

        r7_n0  <= f_mag(s7_n0);
        r7_n1  <= f_mag(s7_n1);
        r7_den <= f_mag(s7_den);
        r7_pay <= n7_pay;
        r7_sn1 <= s7_n1[SW-1] ^ s7_den[SW-1];

        for (int j = 0; j < 3; j++) begin
            ra_p1[j] <= $signed(sa_pay.e1[j]) * sa_t;
            ra_p2[j] <= $signed(sa_pay.e2[j]) * sa_u;
        end
        ra_base   <= sa_pay.base;
        ra_region <= sa_pay.region;
        ra_dgn    <= sa_pay.dgn;

        for (int j = 0; j < 3; j++) begin
            rb_x[j] <= (XW'($signed(ra_base[j])) <<< Q) - XW'(ra_p1[j]) - XW'(ra_p2[j]);
        end
        rb_region <= ra_region;
        rb_dgn    <= ra_dgn;

        rc_region <= rb_region;
        rc_dgn    <= rb_dgn;
        rd_region <= rc_region;
        rd_dgn    <= rc_dgn;

        r_rsp.dist_squared   <= se_dist;
        r_rsp.closest_region <= rd_region;
        r_rsp.degenerate     <= rd_dgn;
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

endmodule

### dv/tb.sv
// Self-checking testbench for point_triangle_distance_squared_unit.
// Depends on pt_pkg and the unit's RTL; a wide-integer predictor checks every response.
`timescale 1ns / 100ps

module tb;
    import pt_pkg::*;

    localparam int QFRAC       = QUOT_FRAC_BITS_DEF;
    localparam int RAND_ITEMS  = 740;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = QFRAC + 40;

    // 256 bits hold every intermediate of the distance math exactly.
    typedef logic signed [255:0] t_wide;
    typedef t_wide t_vec [3];

    typedef struct {
        t_pt_req req;
        bit      typed;   // expected response written in the row
        t_pt_rsp rsp;
    } t_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_pt_req i_req;
    logic    o_valid;
    t_pt_rsp o_rsp;

    t_pt_rsp pending_rsp[$];
    t_pt_rsp typed_rsp[$];
    bit      typed_flag[$];
    int      errors;
    int      cycles;

    point_triangle_distance_squared_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor helpers
    // ---------------------------------------------------------------
    function automatic t_wide dot3(t_vec u, t_vec v);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // Squared length, dropped by shift fraction bits, saturated to 52 bits.
    function automatic logic [DIST_BITS-1:0] sq_length(t_vec d, int shift);
        t_wide s;
        s = dot3(d, d) >>> shift;
        if (s > t_wide'({DIST_BITS{1'b1}}))
            return {DIST_BITS{1'b1}};
        return s[DIST_BITS-1:0];
    endfunction

    // Closest feature and squared distance for one request.
    function automatic t_pt_rsp predict_distance(t_pt_req r);
        t_vec    p, a, b, c, ab, ac, ap, bp, cp, bc, diff;
        t_wide   d1, d2, d3, d4, d5, d6, va, vb, vc, t, u, den;
        bit      zero_div;
        t_region region;
        t_pt_rsp rsp;
        zero_div = 1'b0;
        p[0] = r.point_x;  p[1] = r.point_y;  p[2] = r.point_z;
        a[0] = r.vert_a_x; a[1] = r.vert_a_y; a[2] = r.vert_a_z;
        b[0] = r.vert_b_x; b[1] = r.vert_b_y; b[2] = r.vert_b_z;
        c[0] = r.vert_c_x; c[1] = r.vert_c_y; c[2] = r.vert_c_z;
        for (int i = 0; i < 3; i++) begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
        end
        d1 = dot3(ab, ap); d2 = dot3(ac, ap);
        d3 = dot3(ab, bp); d4 = dot3(ac, bp);
        d5 = dot3(ab, cp); d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;

        if (d1 <= 0 && d2 <= 0) begin
            region = REG_A;
            rsp.dist_squared = sq_length(ap, 0);
        end else if (d3 >= 0 && d4 - d3 <= 0) begin
            region = REG_B;
            rsp.dist_squared = sq_length(bp, 0);
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            region = REG_AB;
            den = d1 - d3;
            zero_div = (den == 0);
            t = zero_div ? t_wide'(0) : (d1 <<< QFRAC) / den;
            for (int i = 0; i < 3; i++) diff[i] = (ap[i] <<< QFRAC) - ab[i] * t;
            rsp.dist_squared = sq_length(diff, 2 * QFRAC);
        end else if (d6 >= 0 && d5 - d6 <= 0) begin
            region = REG_C;
            rsp.dist_squared = sq_length(cp, 0);
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            region = REG_AC;
            den = d2 - d6;
            zero_div = (den == 0);
            t = zero_div ? t_wide'(0) : (d2 <<< QFRAC) / den;
            for (int i = 0; i < 3; i++) diff[i] = (ap[i] <<< QFRAC) - ac[i] * t;
            rsp.dist_squared = sq_length(diff, 2 * QFRAC);
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
            region = REG_BC;
            den = (d4 - d3) + (d5 - d6);
            zero_div = (den == 0);
            t = zero_div ? t_wide'(0) : ((d4 - d3) <<< QFRAC) / den;
            for (int i = 0; i < 3; i++) diff[i] = (bp[i] <<< QFRAC) - bc[i] * t;
            rsp.dist_squared = sq_length(diff, 2 * QFRAC);
        end else begin
            region = REG_FACE;
            den = va + vb + vc;
            zero_div = (den == 0);
            t = zero_div ? t_wide'(0) : (vb <<< QFRAC) / den;
            u = zero_div ? t_wide'(0) : (vc <<< QFRAC) / den;
            for (int i = 0; i < 3; i++)
                diff[i] = (ap[i] <<< QFRAC) - ab[i] * t - ac[i] * u;
            rsp.dist_squared = sq_length(diff, 2 * QFRAC);
        end
        // A zero divisor falls back to the distance to vertex a.
        if (zero_div) rsp.dist_squared = sq_length(ap, 0);
        rsp.closest_region = region;
        rsp.degenerate     = zero_div;
        return rsp;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus builders
    // ---------------------------------------------------------------
    function automatic t_pt_req make_req(int px, int py, int pz, int ax, int ay, int az,
                                         int bx, int by, int bz, int cx, int cy, int cz);
        t_pt_req r;
        r.point_x  = t_coord'(px); r.point_y  = t_coord'(py); r.point_z  = t_coord'(pz);
        r.vert_a_x = t_coord'(ax); r.vert_a_y = t_coord'(ay); r.vert_a_z = t_coord'(az);
        r.vert_b_x = t_coord'(bx); r.vert_b_y = t_coord'(by); r.vert_b_z = t_coord'(bz);
        r.vert_c_x = t_coord'(cx); r.vert_c_y = t_coord'(cy); r.vert_c_z = t_coord'(cz);
        return r;
    endfunction

    function automatic int rand_span(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mix of well-shaped small triangles, full-range noise, slivers and
    // collinear or coincident vertices that drive the zero-divisor path.
    function automatic t_pt_req random_req();
        int   kind, k, span;
        int   o[3], a[3], b[3], c[3], p[3], d[3];
        t_pt_req r;
        kind = $urandom_range(9);
        span = ($urandom_range(3) == 0) ? 3000000 : 2000;
        for (int i = 0; i < 3; i++) begin
            o[i] = rand_span(4000000);
            a[i] = o[i] + rand_span(span);
            b[i] = o[i] + rand_span(span);
            c[i] = o[i] + rand_span(span);
            p[i] = o[i] + rand_span(2 * span);
        end
        if (kind == 0) begin
            r = t_pt_req'({$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
            return r;
        end
        if (kind == 1 || kind == 2) begin
            // collinear: c on the line through a and b, b may equal a
            k = rand_span(3);
            for (int i = 0; i < 3; i++) begin
                d[i] = (kind == 2) ? 0 : rand_span(300);
                b[i] = a[i] + d[i];
                c[i] = a[i] + k * d[i] + ((kind == 2) ? rand_span(300) : 0);
            end
        end else if (kind == 3) begin
            for (int i = 0; i < 3; i++) p[i] = (i == 0) ? b[0] : b[i];
        end else if (kind == 4) begin
            for (int i = 0; i < 3; i++) c[i] = b[i];
        end
        return make_req(p[0], p[1], p[2], a[0], a[1], a[2],
                        b[0], b[1], b[2], c[0], c[1], c[2]);
    endfunction

    // Hand one request over; hold start until the handshake completes.
    task automatic issue_request(t_pt_req r, bit typed, t_pt_rsp rsp, bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_flag = {typed_flag, typed};
        typed_rsp  = {typed_rsp, rsp};
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Scoreboard: predict on accept, compare on strobe
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pt_rsp exp_rsp;
        t_pt_rsp typed_val;
        bit      is_typed;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_rsp.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response %p", $time, o_rsp);
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    if (o_rsp.dist_squared !== exp_rsp.dist_squared ||
                        o_rsp.closest_region !== exp_rsp.closest_region ||
                        o_rsp.degenerate !== exp_rsp.degenerate) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_rsp, o_rsp);
                    end
                end
            end
            if (start && !busy) begin
                is_typed  = typed_flag.pop_front();
                typed_val = typed_rsp.pop_front();
                exp_rsp   = predict_distance(i_req);
                // Hand-typed rows also cross-check the predictor itself.
                if (is_typed && exp_rsp !== typed_val) begin
                    errors++;
                    $display("%0t: table row expected %p predictor %p",
                             $time, typed_val, exp_rsp);
                end
                pending_rsp = {pending_rsp, (is_typed ? typed_val : exp_rsp)};
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        t_row    rows[$];
        t_row    row;
        t_pt_rsp none;
        int      mx, mn;
        errors       = 0;
        cycles       = 0;
        none         = '0;
        mx           = 8388607;
        mn           = -8388608;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req        = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Everything at the origin: vertex a, zero distance.
        row.req = make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        row.typed = 1; row.rsp = '{0, REG_A, 1'b0}; rows = {rows, row};
        // Point triangle at the origin, query at 1.0 on x.
        row.req = make_req(256, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        row.typed = 1; row.rsp = '{65536, REG_A, 1'b0}; rows = {rows, row};
        // Extremes: all vertices at the minimum, query at the maximum.
        row.req = make_req(mx, mx, mx, mn, mn, mn, mn, mn, mn, mn, mn, mn);
        row.typed = 1;
        row.rsp = '{DIST_BITS'(64'd3 * 64'd16777215 * 64'd16777215), REG_A, 1'b0};
        rows = {rows, row};
        // a and b coincide: edge ab test picks a zero divisor.
        row.req = make_req(100, 50, 0, 0, 0, 0, 0, 0, 0, 256, 0, 0);
        row.typed = 1; row.rsp = '{12500, REG_AB, 1'b1}; rows = {rows, row};
        // Unit right triangle with the query in each region in turn.
        row.typed = 0; row.rsp = none;
        row.req = make_req(-100, -100, 50, 0, 0, 0, 256, 0, 0, 0, 256, 0); rows = {rows, row};
        row.req = make_req(400, -50, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);    rows = {rows, row};
        row.req = make_req(128, -100, 10, 0, 0, 0, 256, 0, 0, 0, 256, 0);  rows = {rows, row};
        row.req = make_req(-50, 400, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);    rows = {rows, row};
        row.req = make_req(-100, 128, 7, 0, 0, 0, 256, 0, 0, 0, 256, 0);   rows = {rows, row};
        row.req = make_req(200, 200, 30, 0, 0, 0, 256, 0, 0, 0, 256, 0);   rows = {rows, row};
        row.req = make_req(50, 50, 100, 0, 0, 0, 256, 0, 0, 0, 256, 0);    rows = {rows, row};
        // Collinear vertices and a fully collapsed triangle.
        row.req = make_req(100, 300, 0, 0, 0, 0, 256, 0, 0, 512, 0, 0);    rows = {rows, row};
        row.req = make_req(300, 40, 9, 0, 0, 0, 512, 0, 0, 256, 0, 0);     rows = {rows, row};
        row.req = make_req(5, 6, 7, 9, 9, 9, 9, 9, 9, 9, 9, 9);            rows = {rows, row};
        // Huge triangle spanning the whole range, query at the opposite corner.
        row.req = make_req(mn, mx, mn, mx, mn, mn, mn, mx, mx, mx, mx, mn); rows = {rows, row};
        row.req = make_req(mx, mn, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn); rows = {rows, row};
        row.req = make_req(-1, -1, -1, mx, 0, 0, 0, mx, 0, 0, 0, mx);       rows = {rows, row};
        row.req = make_req(mx, mx, mx, mx, 0, 0, 0, mx, 0, 0, 0, mx);       rows = {rows, row};

        foreach (rows[i]) issue_request(rows[i].req, rows[i].typed, rows[i].rsp, 1'b1);

        for (int n = 0; n < RAND_ITEMS; n++)
            issue_request(random_req(), 1'b0, none, n < RAND_ITEMS - 120);
        start <= 1'b0;

        // Drain: everything in flight must come back, then a quiet tail.
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

### files.f
src/pt_pkg.sv
src/pt_mul.sv
src/pt_div.sv
src/point_triangle_distance_squared_unit.sv
dv/tb.sv
